/* hdl/pfre_pkg.sv */
`timescale 1ns / 1ps
// Shared types, register indexes and the victim ordering rule for the
// page frame replacement engine. No dependencies.
package pfre_pkg;

  localparam int RESIDENT_SLOTS_DEF = 4;
  localparam int FRAME_BITS_DEF     = 8;
  localparam int PAGE_BITS_DEF      = 20;

  localparam int STAMP_BITS        = 32;
  localparam int USES_BITS         = 16;
  localparam int FRAME_COUNT_RESET = 256;

  localparam logic [USES_BITS-1:0] USES_MAX = '1;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 9;

  localparam logic [CFG_INDEX_BITS-1:0] REG_POLICY_MODE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_COUNT = 2'd1;

  typedef enum logic [1:0] {
    POL_FIFO = 2'd0,
    POL_LRU  = 2'd1,
    POL_LFU  = 2'd2,
    POL_MFU  = 2'd3
  } policy_t;

  typedef struct packed {
    logic clear;
    logic start;
    logic commit_hit;
    logic commit_miss;
  } slot_cmd_t;

  typedef struct packed {
    logic done;
    logic hit;
    logic full;
  } slot_stat_t;

  typedef struct packed {
    logic reload;
    logic pop;
    logic push;
  } fl_cmd_t;

  // True when candidate a is a better victim than the current pick b.
  function automatic logic beats(
    input policy_t                mode,
    input logic [USES_BITS-1:0]   uses_a,
    input logic [STAMP_BITS-1:0]  age_a,
    input logic [USES_BITS-1:0]   uses_b,
    input logic [STAMP_BITS-1:0]  age_b
  );
    logic r;
    case (mode)
      POL_LFU: r = (uses_a != uses_b) ? (uses_a < uses_b) : (age_a > age_b);
      POL_MFU: r = (uses_a != uses_b) ? (uses_a > uses_b) : (age_a < age_b);
      default: r = age_a > age_b;
    endcase
    return r;
  endfunction

endpackage

/* hdl/pfre_free_list.sv */
`timescale 1ns / 1ps
// Free frame FIFO: circular memory with head, fill and a push mark that
// stands in for the initial frame numbering. Depends on pfre_pkg.
module pfre_free_list #(
  parameter int FRAME_BITS = pfre_pkg::FRAME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pfre_pkg::fl_cmd_t     cmd,
  input  logic [FRAME_BITS:0]   reload_count,
  input  logic [FRAME_BITS-1:0] push_frame,
  output logic                  empty,
  output logic [FRAME_BITS-1:0] pop_frame
);
  import pfre_pkg::*;

  localparam int FREE_DEPTH  = 1 << FRAME_BITS;
  localparam int CNT_W       = FRAME_BITS + 1;
  localparam int RESET_COUNT = (FRAME_COUNT_RESET < FREE_DEPTH) ? FRAME_COUNT_RESET : FREE_DEPTH;

  logic [FRAME_BITS-1:0] mem [FREE_DEPTH];
  logic [FRAME_BITS-1:0] rd_q;
  logic [FRAME_BITS-1:0] head;
  logic [CNT_W-1:0]      fill;
  logic [CNT_W-1:0]      pushes;
  logic [CNT_W-1:0]      count;
  logic [FRAME_BITS-1:0] tail;
  logic [FRAME_BITS-1:0] offset;
  logic                  written;

  assign tail    = head + fill[FRAME_BITS-1:0];
  assign offset  = head - count[FRAME_BITS-1:0];
  // entries not yet overwritten since reload still hold their own index
  assign written = pushes > {1'b0, offset};
  assign pop_frame = written ? rd_q : head;
  assign empty   = fill == '0;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= push_frame;
    end
    rd_q <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      fill   <= CNT_W'(RESET_COUNT);
      count  <= CNT_W'(RESET_COUNT);
      pushes <= '0;
    end else if (cmd.reload) begin
      head   <= '0;
      fill   <= reload_count;
      count  <= reload_count;
      pushes <= '0;
    end else begin
      if (cmd.pop) begin
        head <= head + 1'b1;
      end
      if (cmd.pop && !cmd.push) begin
        fill <= fill - 1'b1;
      end else if (cmd.push && !cmd.pop) begin
        fill <= fill + 1'b1;
      end
      if (cmd.push && pushes != CNT_W'(FREE_DEPTH)) begin
        pushes <= pushes + 1'b1;
      end
    end
  end

endmodule

/* hdl/pfre_slot_table.sv */
`timescale 1ns / 1ps
// Resident slot memory with a one-slot-per-cycle scan for hit, first empty
// slot and victim, plus the write-back of the access. Depends on pfre_pkg.
module pfre_slot_table #(
  parameter int RESIDENT_SLOTS = pfre_pkg::RESIDENT_SLOTS_DEF,
  parameter int FRAME_BITS     = pfre_pkg::FRAME_BITS_DEF,
  parameter int PAGE_BITS      = pfre_pkg::PAGE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pfre_pkg::slot_cmd_t             cmd,
  input  pfre_pkg::policy_t               mode,
  input  logic [PAGE_BITS-1:0]            page,
  input  logic [pfre_pkg::STAMP_BITS-1:0] now,
  input  logic [FRAME_BITS-1:0]           new_frame,
  output pfre_pkg::slot_stat_t            stat,
  output logic [FRAME_BITS-1:0]           hit_frame,
  output logic [FRAME_BITS-1:0]           vic_frame,
  output logic [PAGE_BITS-1:0]            vic_page
);
  import pfre_pkg::*;

  localparam int SLOT_W = (RESIDENT_SLOTS > 1) ? $clog2(RESIDENT_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(RESIDENT_SLOTS - 1);

  typedef struct packed {
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;
    logic [USES_BITS-1:0]  uses;
    logic [STAMP_BITS-1:0] stamp;
  } entry_t;

  entry_t                    mem [RESIDENT_SLOTS];
  entry_t                    rd_q;
  entry_t                    wr_entry;
  logic [RESIDENT_SLOTS-1:0] valid;
  logic                      scanning;
  logic [SLOT_W-1:0]         eval_idx;
  logic [SLOT_W-1:0]         rd_addr;
  logic [SLOT_W-1:0]         wr_idx;
  logic                      wr_en;
  logic                      last;
  logic                      cur_valid;
  logic                      cur_hit;
  logic                      take_vic;
  logic [STAMP_BITS-1:0]     age;
  logic                      hit_found;
  logic [SLOT_W-1:0]         hit_idx;
  logic [USES_BITS-1:0]      hit_uses;
  logic [STAMP_BITS-1:0]     hit_stamp;
  logic [USES_BITS-1:0]      uses_bump;
  logic                      empty_found;
  logic [SLOT_W-1:0]         empty_idx;
  logic [SLOT_W-1:0]         vic_idx;
  logic [USES_BITS-1:0]      vic_uses;
  logic [STAMP_BITS-1:0]     vic_age;

  assign last      = eval_idx == LAST;
  assign cur_valid = valid[eval_idx];
  assign cur_hit   = cur_valid && (rd_q.page == page);
  assign age       = now - rd_q.stamp;
  assign take_vic  = (eval_idx == '0) || beats(mode, rd_q.uses, age, vic_uses, vic_age);
  assign uses_bump = (hit_uses == USES_MAX) ? hit_uses : hit_uses + 1'b1;

  assign stat.done = scanning && last;
  assign stat.hit  = hit_found;
  assign stat.full = !empty_found;

  always_comb begin
    if (!scanning) begin
      rd_addr = '0;
    end else if (last) begin
      rd_addr = eval_idx;
    end else begin
      rd_addr = eval_idx + 1'b1;
    end
  end

  always_comb begin
    wr_en = cmd.commit_hit || cmd.commit_miss;
    if (cmd.commit_hit) begin
      wr_idx         = hit_idx;
      wr_entry.page  = page;
      wr_entry.frame = hit_frame;
      wr_entry.uses  = uses_bump;
      wr_entry.stamp = (mode == POL_FIFO) ? hit_stamp : now;
    end else begin
      wr_idx         = empty_found ? empty_idx : vic_idx;
      wr_entry.page  = page;
      wr_entry.frame = new_frame;
      wr_entry.uses  = '0;
      wr_entry.stamp = now;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      scanning    <= 1'b0;
      eval_idx    <= '0;
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
    end else begin
      if (cmd.clear) begin
        valid <= '0;
      end else if (cmd.commit_miss) begin
        valid[wr_idx] <= 1'b1;
      end
      if (cmd.start) begin
        scanning    <= 1'b1;
        eval_idx    <= '0;
        hit_found   <= 1'b0;
        empty_found <= 1'b0;
      end else if (scanning) begin
        if (cur_hit) begin
          hit_found <= 1'b1;
        end
        if (!cur_valid) begin
          empty_found <= 1'b1;
        end
        if (last) begin
          scanning <= 1'b0;
        end else begin
          eval_idx <= eval_idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scanning) begin
      if (cur_hit && !hit_found) begin
        hit_idx   <= eval_idx;
        hit_frame <= rd_q.frame;
        hit_uses  <= rd_q.uses;
        hit_stamp <= rd_q.stamp;
      end
      if (!cur_valid && !empty_found) begin
        empty_idx <= eval_idx;
      end
      if (take_vic) begin
        vic_idx   <= eval_idx;
        vic_uses  <= rd_q.uses;
        vic_age   <= age;
        vic_frame <= rd_q.frame;
        vic_page  <= rd_q.page;
      end
    end
  end

endmodule

/* hdl/page_frame_replacement_engine.sv */
`timescale 1ns / 1ps
// Page frame replacement engine: access sequencer, configuration registers
// and result registers. Depends on pfre_pkg, pfre_slot_table, pfre_free_list.
//
// Usage:
//   Access channel: an access transfer happens when start is high and busy is
//   low; virtual_page is sampled then. busy stays high while it is processed.
//   Result: done pulses for one cycle with hit, accepted, mapped_frame and
//   the eviction fields. The receiver cannot stall; each result is taken in
//   its cycle.
//   Timing: the slot memory is scanned one slot per cycle through its single
//   read port; busy covers the scan state and the finish state, and done
//   rises as busy falls. A new access can be taken in the cycle done is high,
//   so accesses are processed one at a time.
//   Configuration: cfg_ready is always high; index 0 selects the victim rule,
//   index 1 loads the frame count, which reloads the free list, empties all
//   slots and clears the access clock. Write only while busy is low.
//   Reset: rule FIFO, frame count 256 (capped at the frame space), all slots
//   empty, free list holding frames in order. No clearing pass is needed.
module page_frame_replacement_engine #(
  parameter int RESIDENT_SLOTS = pfre_pkg::RESIDENT_SLOTS_DEF,
  parameter int FRAME_BITS     = pfre_pkg::FRAME_BITS_DEF,
  parameter int PAGE_BITS      = pfre_pkg::PAGE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [PAGE_BITS-1:0]                virtual_page,
  output logic                                done,
  output logic                                hit,
  output logic                                accepted,
  output logic [FRAME_BITS-1:0]               mapped_frame,
  output logic                                evicted_valid,
  output logic [FRAME_BITS-1:0]               evicted_frame,
  output logic [PAGE_BITS-1:0]                evicted_page,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pfre_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [pfre_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import pfre_pkg::*;

  localparam int FREE_DEPTH = 1 << FRAME_BITS;
  localparam int CNT_W      = FRAME_BITS + 1;
  localparam int CMP_W      = (CFG_DATA_BITS > CNT_W) ? CFG_DATA_BITS : CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t                state;
  state_t                state_next;
  policy_t               mode;
  logic [STAMP_BITS-1:0] access_clock;
  logic [PAGE_BITS-1:0]  page_q;
  logic                  take;
  logic                  reg_wr;
  logic                  mode_we;
  logic                  reload;
  logic [CMP_W-1:0]      cnt_wide;
  logic [CNT_W-1:0]      count_new;
  slot_cmd_t             slot_cmd;
  slot_stat_t            slot_stat;
  fl_cmd_t               fl_cmd;
  logic                  fl_empty;
  logic [FRAME_BITS-1:0] pop_frame;
  logic [FRAME_BITS-1:0] hit_frame;
  logic [FRAME_BITS-1:0] vic_frame;
  logic [PAGE_BITS-1:0]  vic_page;
  logic                  finish;
  logic                  miss_ok;
  logic                  evict;

  assign busy      = state != ST_IDLE;
  assign take      = start && (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign reg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    mode_we = 1'b0;
    reload  = 1'b0;
    if (reg_wr) begin
      unique case (cfg_index)
        REG_POLICY_MODE: mode_we = 1'b1;
        REG_FRAME_COUNT: reload  = 1'b1;
        default: ;
      endcase
    end
  end

  assign cnt_wide  = CMP_W'(cfg_data);
  assign count_new = (cnt_wide > CMP_W'(FREE_DEPTH)) ? CNT_W'(FREE_DEPTH) : CNT_W'(cnt_wide);

  assign finish  = state == ST_FINISH;
  assign miss_ok = finish && !slot_stat.hit && !fl_empty;
  assign evict   = miss_ok && slot_stat.full;

  assign slot_cmd.clear       = reload;
  assign slot_cmd.start       = take;
  assign slot_cmd.commit_hit  = finish && slot_stat.hit;
  assign slot_cmd.commit_miss = miss_ok;

  assign fl_cmd.reload = reload;
  assign fl_cmd.pop    = miss_ok;
  assign fl_cmd.push   = evict;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_SCAN;
      ST_SCAN:   if (slot_stat.done) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      mode         <= POL_FIFO;
      access_clock <= '0;
      done         <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
      if (mode_we) begin
        mode <= policy_t'(cfg_data[1:0]);
      end
      if (reload) begin
        access_clock <= '0;
      end else if (take) begin
        access_clock <= access_clock + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      page_q <= virtual_page;
    end
    if (finish) begin
      hit           <= slot_stat.hit;
      accepted      <= slot_stat.hit || !fl_empty;
      mapped_frame  <= slot_stat.hit ? hit_frame : (miss_ok ? pop_frame : '0);
      evicted_valid <= evict;
      evicted_frame <= evict ? vic_frame : '0;
      evicted_page  <= evict ? vic_page : '0;
    end
  end

  pfre_slot_table #(
    .RESIDENT_SLOTS(RESIDENT_SLOTS),
    .FRAME_BITS    (FRAME_BITS),
    .PAGE_BITS     (PAGE_BITS)
  ) u_slots (
    .clk      (clk),
    .rst      (rst),
    .cmd      (slot_cmd),
    .mode     (mode),
    .page     (page_q),
    .now      (access_clock),
    .new_frame(pop_frame),
    .stat     (slot_stat),
    .hit_frame(hit_frame),
    .vic_frame(vic_frame),
    .vic_page (vic_page)
  );

  pfre_free_list #(
    .FRAME_BITS(FRAME_BITS)
  ) u_free (
    .clk         (clk),
    .rst         (rst),
    .cmd         (fl_cmd),
    .reload_count(count_new),
    .push_frame  (vic_frame),
    .empty       (fl_empty),
    .pop_frame   (pop_frame)
  );

`ifndef SYNTHESIS
  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_FINISH))
    else $error("result strobe without a finishing access");

  a_evict_only_on_miss: assert property (@(posedge clk) disable iff (rst)
    (done && evicted_valid) |-> (accepted && !hit))
    else $error("eviction reported on a hit or refused access");

  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    slot_stat.done |-> (state == ST_SCAN))
    else $error("slot scan completed outside the scan state");

  a_take_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("access transfer did not raise busy");
`endif

endmodule

/* bench/tb_page_frame_replacement_engine.sv */
`timescale 1ns / 1ps
// Self-checking bench for page_frame_replacement_engine: a queue-fed access driver,
// a result monitor and an in-bench model of slots, free frames and victim choice.
// Depends on pfre_pkg and the engine RTL.
module tb_page_frame_replacement_engine;
  import pfre_pkg::*;

  localparam int SLOTS = RESIDENT_SLOTS_DEF;
  localparam int FB = FRAME_BITS_DEF;
  localparam int PB = PAGE_BITS_DEF;
  localparam int RING = 1 << FB;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int MAX_PRINTS = 40;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic hit;
    logic accepted;
    logic [FB-1:0] mapped_frame;
    logic evicted_valid;
    logic [FB-1:0] evicted_frame;
    logic [PB-1:0] evicted_page;
  } mapping_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [PB-1:0] virtual_page = '0;
  logic done;
  logic hit;
  logic accepted;
  logic [FB-1:0] mapped_frame;
  logic evicted_valid;
  logic [FB-1:0] evicted_frame;
  logic [PB-1:0] evicted_page;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  page_frame_replacement_engine dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .virtual_page(virtual_page),
    .done(done),
    .hit(hit),
    .accepted(accepted),
    .mapped_frame(mapped_frame),
    .evicted_valid(evicted_valid),
    .evicted_frame(evicted_frame),
    .evicted_page(evicted_page),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // mirror of the engine state
  logic [PB-1:0] res_page [SLOTS];
  logic [FB-1:0] res_frame [SLOTS];
  logic [USES_BITS-1:0] res_uses [SLOTS];
  logic [STAMP_BITS-1:0] res_stamp [SLOTS];
  logic [SLOTS-1:0] res_live;
  logic [FB-1:0] spare_ring [RING];
  logic [FB-1:0] spare_head;
  logic [FB:0] spare_fill;
  logic [STAMP_BITS-1:0] access_tick;
  policy_t rule;
  logic [CFG_DATA_BITS-1:0] nframes;

  logic [PB-1:0] page_q [$];
  mapping_t mapping_q [$];
  mapping_t want;
  mapping_t outcome;
  int send_idle_pct = 35;
  int errors = 0;
  int cycles = 0;
  int n_access = 0;
  int n_hit = 0;
  int n_evict = 0;
  int n_refused = 0;

  function automatic void refill_frames();
    for (int k = 0; k < RING; k++) spare_ring[k] = (k < nframes) ? FB'(k) : '0;
    res_live = '0;
    spare_head = '0;
    spare_fill = nframes;
    access_tick = '0;
  endfunction

  function automatic mapping_t map_access(input logic [PB-1:0] vpn);
    mapping_t r;
    int hs;
    int es;
    int vs;
    bit take;
    logic [STAMP_BITS-1:0] age_s;
    logic [STAMP_BITS-1:0] age_v;
    logic [FB-1:0] frm;
    logic [FB-1:0] tail;
    r = '0;
    hs = -1;
    es = -1;
    access_tick = access_tick + 1'b1;
    for (int s = 0; s < SLOTS; s++) begin
      if (res_live[s] && res_page[s] == vpn && hs < 0) hs = s;
      if (!res_live[s] && es < 0) es = s;
    end
    if (hs >= 0) begin
      if (res_uses[hs] != USES_MAX) res_uses[hs] = res_uses[hs] + 1'b1;
      if (rule != POL_FIFO) res_stamp[hs] = access_tick;
      r.hit = 1'b1;
      r.accepted = 1'b1;
      r.mapped_frame = res_frame[hs];
      return r;
    end
    if (spare_fill == 0) return r;
    frm = spare_ring[spare_head];
    spare_head = spare_head + 1'b1;
    spare_fill = spare_fill - 1'b1;
    if (es < 0) begin
      vs = 0;
      for (int s = 1; s < SLOTS; s++) begin
        age_s = access_tick - res_stamp[s];
        age_v = access_tick - res_stamp[vs];
        case (rule)
          POL_LFU: take = (res_uses[s] != res_uses[vs]) ? (res_uses[s] < res_uses[vs])
                                                        : (age_s > age_v);
          POL_MFU: take = (res_uses[s] != res_uses[vs]) ? (res_uses[s] > res_uses[vs])
                                                        : (age_s < age_v);
          default: take = age_s > age_v;
        endcase
        if (take) vs = s;
      end
      tail = spare_head + spare_fill[FB-1:0];
      spare_ring[tail] = res_frame[vs];
      spare_fill = spare_fill + 1'b1;
      r.evicted_valid = 1'b1;
      r.evicted_frame = res_frame[vs];
      r.evicted_page = res_page[vs];
      es = vs;
    end
    res_live[es] = 1'b1;
    res_page[es] = vpn;
    res_frame[es] = frm;
    res_uses[es] = '0;
    res_stamp[es] = access_tick;
    r.accepted = 1'b1;
    r.mapped_frame = frm;
    return r;
  endfunction

  task automatic report(input string what);
    errors++;
    if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // waits until every queued access has been taken and answered
  task automatic drain();
    do @(posedge clk);
    while (page_q.size() != 0 || start || busy || mapping_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      REG_POLICY_MODE: rule = policy_t'(val[1:0]);
      REG_FRAME_COUNT: begin
        nframes = (val > RING) ? CFG_DATA_BITS'(RING) : val;
        refill_frames();
      end
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // access driver: holds start while busy, takes pages from page_q
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        outcome = map_access(virtual_page);
        mapping_q = {mapping_q, outcome};
        n_access++;
        if (outcome.hit) n_hit++;
        if (outcome.evicted_valid) n_evict++;
        if (!outcome.accepted) n_refused++;
      end
      if (!start || !busy) begin
        if (page_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          start <= 1'b1;
          virtual_page <= page_q[0];
          page_q.delete(0);
        end else begin
          start <= 1'b0;
          virtual_page <= PB'($urandom);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (mapping_q.size() == 0) begin
        report("result with no access outstanding");
      end else begin
        want = mapping_q[0];
        mapping_q.delete(0);
        if (hit !== want.hit)
          report($sformatf("hit %b, expected %b", hit, want.hit));
        if (accepted !== want.accepted)
          report($sformatf("accepted %b, expected %b", accepted, want.accepted));
        if (mapped_frame !== want.mapped_frame)
          report($sformatf("mapped_frame %0h, expected %0h", mapped_frame, want.mapped_frame));
        if (evicted_valid !== want.evicted_valid)
          report($sformatf("evicted_valid %b, expected %b", evicted_valid,
                           want.evicted_valid));
        if (evicted_frame !== want.evicted_frame)
          report($sformatf("evicted_frame %0h, expected %0h", evicted_frame,
                           want.evicted_frame));
        if (evicted_page !== want.evicted_page)
          report($sformatf("evicted_page %0h, expected %0h", evicted_page,
                           want.evicted_page));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int roll;
    int span;
    logic [PB-1:0] base;
    logic [PB-1:0] pg;
    logic [CFG_DATA_BITS-1:0] cnt;
    rule = POL_FIFO;
    nframes = (FRAME_COUNT_RESET > RING) ? CFG_DATA_BITS'(RING) : CFG_DATA_BITS'(FRAME_COUNT_RESET);
    refill_frames();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // FIFO from reset: page extremes, hit keeps load stamp, evictions
    page_q = '{20'h00000, 20'hFFFFF, 20'h00000, 20'h55555, 20'hAAAAA, 20'h12345, 20'h00000};
    drain();
    // LRU with five frames: hit refreshes stamp, eviction recycles frames
    write_reg(REG_POLICY_MODE, CFG_DATA_BITS'(POL_LRU));
    write_reg(REG_FRAME_COUNT, 9'd5);
    page_q = '{20'd10, 20'd11, 20'd12, 20'd13, 20'd10, 20'd14, 20'd11};
    drain();
    // LFU on the same residents: counts survive a rule change
    write_reg(REG_POLICY_MODE, CFG_DATA_BITS'(POL_LFU));
    page_q = '{20'd13, 20'd13, 20'd14, 20'd20, 20'd21};
    drain();
    // MFU, two frames: miss refused while a slot is still empty
    write_reg(REG_FRAME_COUNT, 9'd2);
    write_reg(REG_POLICY_MODE, CFG_DATA_BITS'(POL_MFU));
    page_q = '{20'd30, 20'd31, 20'd32, 20'd30, 20'd31};
    drain();
    // no frames at all, ignored indexes, oversized count
    write_reg(REG_FRAME_COUNT, 9'd0);
    page_q = '{20'd40};
    drain();
    write_reg(REG_SPARE_A, 9'h1FF);
    write_reg(REG_SPARE_B, 9'h0AA);
    write_reg(REG_FRAME_COUNT, 9'h1FF);
    page_q = '{20'd41, 20'd42};
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 70 : 0;
      for (int blk = 0; blk < 6; blk++) begin
        drain();
        if ($urandom_range(99) < 50) begin
          roll = $urandom_range(99);
          if (roll < 5) cnt = '0;
          else if (roll < 60) cnt = CFG_DATA_BITS'($urandom_range(8, 1));
          else if (roll < 75) cnt = CFG_DATA_BITS'(RING);
          else if (roll < 90) cnt = CFG_DATA_BITS'($urandom_range(RING - 1, 9));
          else cnt = CFG_DATA_BITS'($urandom_range(511, RING + 1));
          write_reg(REG_FRAME_COUNT, cnt);
        end
        if ($urandom_range(99) < 15)
          write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_BITS'($urandom));
        write_reg(REG_POLICY_MODE, CFG_DATA_BITS'($urandom));
        base = PB'($urandom);
        span = $urandom_range(9, 3);
        for (int i = 0; i < 72; i++) begin
          if (i == 36) drain();
          roll = $urandom_range(99);
          if (roll < 75) pg = base + PB'($urandom_range(span - 1));
          else if (roll < 82) pg = roll[0] ? '1 : '0;
          else pg = PB'($urandom);
          page_q = {page_q, pg};
        end
      end
    end

    // hot page under MFU: the most used resident is the one evicted
    drain();
    write_reg(REG_FRAME_COUNT, CFG_DATA_BITS'(RING));
    write_reg(REG_POLICY_MODE, CFG_DATA_BITS'(POL_MFU));
    base = PB'($urandom);
    for (int i = 0; i < 40; i++) page_q = {page_q, base};
    for (int i = 1; i <= SLOTS; i++) page_q = {page_q, base + PB'(i)};
    drain();
    repeat (SLOTS + 4) @(posedge clk);

    $display("%0d accesses under all four victim rules, frame counts from 0 to saturation",
             n_access);
    $display("%0d hits, %0d evictions, %0d refused misses", n_hit, n_evict, n_refused);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/pfre_pkg.sv
hdl/pfre_free_list.sv
hdl/pfre_slot_table.sv
hdl/page_frame_replacement_engine.sv
bench/tb_page_frame_replacement_engine.sv
